### src/lwps_pkg.sv
// ----------------------------------------------------------------------------
// lwps_pkg: shared types and constants of the window pixel streamer
// Queue entry layout, header byte positions and configuration register codes.
// ----------------------------------------------------------------------------
package lwps_pkg;

  localparam int COORD_BITS = 16;                 // coordinate bits in use, 8..16
  localparam int DIFF_W     = COORD_BITS + 1;     // window extent, 1..2^COORD_BITS
  localparam int PIX_W      = 2 * COORD_BITS + 1; // pixel count width
  localparam int PROD_W     = 2 * DIFF_W;

  localparam int QDEPTH  = 2;                     // power of two
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int MONO_BITS = 8;                   // pixels per mono byte
  localparam int NPIX_W    = $clog2(MONO_BITS + 1);
  localparam int IDX_W     = $clog2(2 * MONO_BITS);
  localparam int LEN_W     = IDX_W + 1;

  // header byte positions
  localparam logic [IDX_W-1:0] HB_COL_CMD = IDX_W'(0);
  localparam logic [IDX_W-1:0] HB_X1_HI   = IDX_W'(1);
  localparam logic [IDX_W-1:0] HB_X1_LO   = IDX_W'(2);
  localparam logic [IDX_W-1:0] HB_X2_HI   = IDX_W'(3);
  localparam logic [IDX_W-1:0] HB_X2_LO   = IDX_W'(4);
  localparam logic [IDX_W-1:0] HB_ROW_CMD = IDX_W'(5);
  localparam logic [IDX_W-1:0] HB_Y1_HI   = IDX_W'(6);
  localparam logic [IDX_W-1:0] HB_Y1_LO   = IDX_W'(7);
  localparam logic [IDX_W-1:0] HB_Y2_HI   = IDX_W'(8);
  localparam logic [IDX_W-1:0] HB_Y2_LO   = IDX_W'(9);
  localparam logic [IDX_W-1:0] HB_MEM_CMD = IDX_W'(10);

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // pixel modes
  localparam logic [1:0] MODE_BITMAP = 2'd0;
  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_SOLID  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_COL_OP = 2'd0;
  localparam logic [1:0] REG_ROW_OP = 2'd1;
  localparam logic [1:0] REG_MEM_OP = 2'd2;

  localparam logic [7:0] COL_OP_RESET = 8'd42;
  localparam logic [7:0] ROW_OP_RESET = 8'd43;
  localparam logic [7:0] MEM_OP_RESET = 8'd44;

  typedef struct packed {
    logic [7:0] col_op;
    logic [7:0] row_op;
    logic [7:0] mem_op;
  } cfg_t;

  // One unit of work for the back end. Header: c0..c3 = x1, x2, y1, y2.
  // Pixels: c0 = colour for a set bit, c1 = colour for a clear bit.
  typedef struct packed {
    logic              hdr;
    logic              last;
    logic [NPIX_W-1:0] npix;
    logic [7:0]        bits;
    logic [15:0]       c0;
    logic [15:0]       c1;
    logic [15:0]       c2;
    logic [15:0]       c3;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t ent;
  } push_t;

endpackage

### src/lcd_window_pixel_streamer_core.sv
// ----------------------------------------------------------------------------
// lcd_window_pixel_streamer_core: display window write byte streamer
// Turns window start and pixel data items into the command/parameter/pixel
// byte stream of an RGB565 display controller.
// ----------------------------------------------------------------------------
// The first byte of an item passes through the work queue, then the output register.
// Throughput: one output byte per cycle while out_ready_i is high; a start item
//   gives 11 bytes, bitmap or solid 2, mono up to 16. The byte serialiser sets the rate.
// A start item holds input ready low for one cycle while the window size
//   product is loaded into the pixel counter.
// Reset: asynchronous, active low; opcodes return to 42/43/44, no window active.
// ----------------------------------------------------------------------------
module lcd_window_pixel_streamer_core import lwps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] x_start_i,
  input  logic [15:0] y_start_i,
  input  logic [15:0] x_end_i,
  input  logic [15:0] y_end_i,
  input  logic [1:0]  pixel_mode_i,
  input  logic [15:0] fore_color_i,
  input  logic [15:0] back_color_i,
  input  logic [15:0] pixel_data_i,
  // output byte channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        is_data_o,
  output logic        last_o
);

  cfg_t   cfg_q, cfg_d;
  push_t  wr;
  logic   q_full, q_valid, q_pop;
  entry_t q_ent;

  // Configuration: always ready; writes to an unlisted index are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COL_OP: cfg_d.col_op = cfg_data_i;
        REG_ROW_OP: cfg_d.row_op = cfg_data_i;
        REG_MEM_OP: cfg_d.mem_op = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col_op <= COL_OP_RESET;
      cfg_q.row_op <= ROW_OP_RESET;
      cfg_q.mem_op <= MEM_OP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: accept each transfer, track the window, queue the work.
  lwps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .pixel_mode_i (pixel_mode_i),
    .fore_color_i (fore_color_i),
    .back_color_i (back_color_i),
    .pixel_data_i (pixel_data_i),
    .q_full_i     (q_full),
    .wr_o         (wr)
  );

  // Queue: lets the front take the next item while bytes still drain.
  lwps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .ent_o   (q_ent)
  );

  // Back end: advance one byte per output transfer, drop the entry when done.
  lwps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ent_valid_i (q_valid),
    .ent_i       (q_ent),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .is_data_o   (is_data_o),
    .last_o      (last_o)
  );

endmodule

### src/lwps_fifo.sv
// ----------------------------------------------------------------------------
// lwps_fifo: short work queue between front and back end
// Register-based ring of QDEPTH entries, first in first out.
// ----------------------------------------------------------------------------
module lwps_fifo import lwps_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  wr_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t ent_o
);

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign ent_o   = mem_q[rd_ptr_q];
  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.ent;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("work queue count beyond depth");

  a_push_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
    else $error("push not reflected in queue count");

  a_pop_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - QCNT_W'(1)))
    else $error("pop not reflected in queue count");

endmodule

### src/lwps_front.sv
// ----------------------------------------------------------------------------
// lwps_front: input acceptance and classification
// Latches window state, counts pixels off per item and queues work entries.
// ----------------------------------------------------------------------------
module lwps_front import lwps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] x_start_i,
  input  logic [15:0] y_start_i,
  input  logic [15:0] x_end_i,
  input  logic [15:0] y_end_i,
  input  logic [1:0]  pixel_mode_i,
  input  logic [15:0] fore_color_i,
  input  logic [15:0] back_color_i,
  input  logic [15:0] pixel_data_i,
  input  logic        q_full_i,
  output push_t       wr_o
);

  logic [PIX_W-1:0]      left_q, left_d;
  logic [1:0]            mode_q, mode_d;
  logic [15:0]           fore_q, fore_d, back_q, back_d;
  logic                  pend_q, pend_d;   // window size product still to load
  logic                  empty_q, empty_d;
  logic [DIFF_W-1:0]     dx_q, dx_d, dy_q, dy_d;
  logic [COORD_BITS-1:0] x1, y1, x2, y2;
  logic [PROD_W-1:0]     prod;
  logic                  accept, reversed;
  logic [NPIX_W-1:0]     npix;
  logic [PIX_W-1:0]      left_after;

  assign in_ready_o = !pend_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign x1 = x_start_i[COORD_BITS-1:0];
  assign y1 = y_start_i[COORD_BITS-1:0];
  assign x2 = x_end_i[COORD_BITS-1:0];
  assign y2 = y_end_i[COORD_BITS-1:0];
  assign reversed = (x2 < x1) || (y2 < y1);
  assign prod = dx_q * dy_q;

  always_comb begin
    if ((mode_q == MODE_MONO) && (left_q < PIX_W'(MONO_BITS))) begin
      npix = left_q[NPIX_W-1:0];
    end else if (mode_q == MODE_MONO) begin
      npix = NPIX_W'(MONO_BITS);
    end else begin
      npix = NPIX_W'(1);
    end
    left_after = left_q - PIX_W'(npix);
  end

  always_comb begin
    left_d  = left_q;
    mode_d  = mode_q;
    fore_d  = fore_q;
    back_d  = back_q;
    pend_d  = 1'b0;
    empty_d = empty_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    wr_o    = '0;

    if (pend_q) begin
      left_d = empty_q ? '0 : prod[PIX_W-1:0];
    end

    if (accept && (cmd_i == CMD_START)) begin
      mode_d  = pixel_mode_i;
      fore_d  = fore_color_i;
      back_d  = back_color_i;
      pend_d  = 1'b1;
      empty_d = reversed;
      dx_d    = DIFF_W'(x2) - DIFF_W'(x1) + DIFF_W'(1);
      dy_d    = DIFF_W'(y2) - DIFF_W'(y1) + DIFF_W'(1);
      left_d  = '0;
      wr_o.push     = 1'b1;
      wr_o.ent.hdr  = 1'b1;
      wr_o.ent.last = reversed;
      wr_o.ent.c0   = 16'(x1);
      wr_o.ent.c1   = 16'(x2);
      wr_o.ent.c2   = 16'(y1);
      wr_o.ent.c3   = 16'(y2);
    end else if (accept && (left_q != '0)) begin
      left_d        = left_after;
      wr_o.push     = 1'b1;
      wr_o.ent.last = (left_after == '0);
      wr_o.ent.npix = npix;
      wr_o.ent.bits = 8'hff;
      case (mode_q)
        MODE_BITMAP: begin
          wr_o.ent.c0 = pixel_data_i;
        end
        MODE_MONO: begin
          wr_o.ent.bits = pixel_data_i[7:0];
          wr_o.ent.c0   = fore_q;
          wr_o.ent.c1   = back_q;
        end
        default: begin
          wr_o.ent.c0 = fore_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      mode_q  <= MODE_BITMAP;
      fore_q  <= '0;
      back_q  <= '0;
      pend_q  <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      left_q  <= left_d;
      mode_q  <= mode_d;
      fore_q  <= fore_d;
      back_q  <= back_d;
      pend_q  <= pend_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
  end

  a_pend_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> !pend_q)
    else $error("window size load lasted more than one cycle");

  a_no_accept_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o)
    else $error("input taken while window size loading");

  a_data_push_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.push && !wr_o.ent.hdr) |-> (wr_o.ent.npix != '0))
    else $error("pixel entry queued with no pixels");

endmodule

### src/lwps_back.sv
// ----------------------------------------------------------------------------
// lwps_back: byte serialiser
// Walks each queued entry one byte per cycle into the output register, unless stalled.
// ----------------------------------------------------------------------------
module lwps_back import lwps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       ent_valid_i,
  input  entry_t     ent_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_data_o,
  output logic       last_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             ov_q, ov_d;
  logic [7:0]       byte_q, byte_d;
  logic             isd_q, isd_d, last_q, last_d;
  logic             advance, fin;
  logic [LEN_W-1:0] pix_len;
  logic [15:0]      colour;
  logic [7:0]       hbyte;
  logic             hisd;

  assign advance = !ov_q || out_ready_i;
  assign pix_len = LEN_W'({ent_i.npix, 1'b0});
  assign fin     = ent_i.hdr ? (idx_q == HB_MEM_CMD)
                             : (LEN_W'(idx_q) == pix_len - LEN_W'(1));
  assign pop_o   = advance && ent_valid_i && fin;
  assign colour  = ent_i.bits[idx_q[IDX_W-1:1]] ? ent_i.c0 : ent_i.c1;

  always_comb begin
    hisd = 1'b1;
    case (idx_q)
      HB_COL_CMD: begin hbyte = cfg_i.col_op; hisd = 1'b0; end
      HB_X1_HI:   hbyte = ent_i.c0[15:8];
      HB_X1_LO:   hbyte = ent_i.c0[7:0];
      HB_X2_HI:   hbyte = ent_i.c1[15:8];
      HB_X2_LO:   hbyte = ent_i.c1[7:0];
      HB_ROW_CMD: begin hbyte = cfg_i.row_op; hisd = 1'b0; end
      HB_Y1_HI:   hbyte = ent_i.c2[15:8];
      HB_Y1_LO:   hbyte = ent_i.c2[7:0];
      HB_Y2_HI:   hbyte = ent_i.c3[15:8];
      HB_Y2_LO:   hbyte = ent_i.c3[7:0];
      HB_MEM_CMD: begin hbyte = cfg_i.mem_op; hisd = 1'b0; end
      default:    hbyte = '0;
    endcase
  end

  always_comb begin
    idx_d  = idx_q;
    ov_d   = ov_q;
    byte_d = byte_q;
    isd_d  = isd_q;
    last_d = last_q;
    if (advance) begin
      ov_d = ent_valid_i;
      if (ent_valid_i) begin
        idx_d  = fin ? '0 : idx_q + IDX_W'(1);
        last_d = fin && ent_i.last;
        if (ent_i.hdr) begin
          byte_d = hbyte;
          isd_d  = hisd;
        end else begin
          byte_d = idx_q[0] ? colour[7:0] : colour[15:8];
          isd_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    isd_q  <= isd_d;
    last_q <= last_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign is_data_o   = isd_q;
  assign last_o      = last_q;

  a_hdr_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_valid_i && ent_i.hdr) |-> (idx_q <= HB_MEM_CMD))
    else $error("header byte index out of range");

  a_pix_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ent_valid_i && !ent_i.hdr) |-> (LEN_W'(idx_q) < pix_len))
    else $error("pixel byte index out of range");

  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ent_valid_i |-> (idx_q == '0))
    else $error("byte index left mid-entry with queue empty");

endmodule
